[hdl/mkvt_pkg.sv]
// Shared types and codes for the memory-key validation table.
`default_nettype none

package mkvt_pkg;

	// Action codes of a request item
	localparam logic [1:0] ACT_ADD        = 2'd0;
	localparam logic [1:0] ACT_VALIDATE   = 2'd1;
	localparam logic [1:0] ACT_REM_BOTH   = 2'd2;
	localparam logic [1:0] ACT_REM_REMOTE = 2'd3;

	// Status codes of a response item
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_EXISTS   = 3'd2;
	localparam logic [2:0] ST_NO_ENTRY = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// Configuration register indexes
	localparam logic CFG_ENFORCE = 1'b0;
	localparam logic CFG_STRIP   = 1'b1;

	// One table record as stored in the record RAM
	typedef struct packed {
		logic        live;
		logic [31:0] lkey;
		logic [31:0] rkey;
		logic [63:0] base;
		logic [63:0] length;
		logic [63:0] access;
	} rec_t;

endpackage

`default_nettype wire

[hdl/mkvt_in_if.sv]
// Request channel: valid/ready handshake with the request payload.
`default_nettype none

interface mkvt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] local_key;
	logic [31:0] remote_key;
	logic [63:0] region_base;
	logic [63:0] region_length;
	logic [63:0] access_bits;

	modport source (
		output valid, action, local_key, remote_key, region_base, region_length,
		       access_bits,
		input  ready
	);
	modport sink (
		input  valid, action, local_key, remote_key, region_base, region_length,
		       access_bits,
		output ready
	);
endinterface

`default_nettype wire

[hdl/mkvt_out_if.sv]
// Response channel: valid/ready handshake with the status payload.
`default_nettype none

interface mkvt_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;

	modport source (
		output valid, status,
		input  ready
	);
	modport sink (
		input  valid, status,
		output ready
	);
endinterface

`default_nettype wire

[hdl/mkvt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mkvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hdl/memory_key_validation_table.sv]
// Top level of the memory-key validation table: scan sequencer around a record RAM.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------------
//   req     | in        | req.valid/ready   | action, keys, region base/length, access
//   rsp     | out       | rsp.valid/ready   | status
//   cfg     | in        | cfg_we            | cfg_index, cfg_wdata (write only)
//
// An enforced item, once accepted, runs one pass over the record RAM (one read a cycle,
// then the outstanding read and the end-of-scan check), a decide state that writes back,
// a range check state and a state that hands the status to the response register, after
// which the block is back in idle and can accept the next item.
// With enforcement off an item goes from idle straight to the hand-off state.
// After reset a clearing pass writes every RAM entry with req.ready low.
// A status waiting in the response register does not block the next request; a stalled
// response holds the block in its final state until the register frees up.
`default_nettype none

module memory_key_validation_table #(
	parameter int ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mkvt_in_if.sink          req,
	mkvt_out_if.source       rsp,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_wdata
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RW = $bits(mkvt_pkg::rec_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_CHECK,
		S_FINISH
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;

	// configuration
	logic        enforce_q;
	logic [63:0] strip_q;

	// captured request
	logic [1:0]  act_q;
	logic [31:0] lkey_q;
	logic [31:0] rkey_q;
	logic [63:0] base_q;
	logic [63:0] len_q;
	logic [63:0] acc_q;

	// scan results
	logic           free_found_q;
	logic [AW-1:0]  free_idx_q;
	logic           hit_found_q;
	logic [AW-1:0]  hit_idx_q;
	mkvt_pkg::rec_t hit_rec_q;
	logic           dup_q;

	// read pipeline
	logic rd_valid_s1;

	// range check operands
	logic [64:0] rec_end_q;
	logic [64:0] req_end_q;
	logic        extra_bits_q;

	logic [2:0] status_q;

	// response register
	logic       out_valid_q;
	logic [2:0] out_status_q;

	// RAM ports
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	mkvt_pkg::rec_t ram_wrec;
	logic [RW-1:0]  ram_rdata;
	mkvt_pkg::rec_t rd_rec;

	logic scan_issue;
	logic scan_done;
	logic lk_match;
	logic rk_match;
	logic hit_now;
	logic write_add;
	logic write_rem;
	logic is_add;

	mkvt_ram #(
		.WIDTH(RW),
		.DEPTH(ENTRIES)
	) u_rec_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wrec),
		.raddr(cnt_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_rec = mkvt_pkg::rec_t'(ram_rdata);

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;

	// Issue one read per cycle until every entry has been requested.
	assign scan_issue = (state_q == S_SCAN) && (cnt_q < CW'(ENTRIES));
	assign scan_done  = (state_q == S_SCAN) && !scan_issue && !rd_valid_s1;

	// Key compare on the record coming out of the RAM.
	assign lk_match = rd_rec.live && (rd_rec.lkey == lkey_q);
	assign rk_match = rd_rec.live && (rd_rec.rkey == rkey_q);

	always_comb begin
		unique case (act_q)
			mkvt_pkg::ACT_ADD:        hit_now = lk_match;
			mkvt_pkg::ACT_VALIDATE:   hit_now = lk_match;
			mkvt_pkg::ACT_REM_BOTH:   hit_now = lk_match && rk_match;
			mkvt_pkg::ACT_REM_REMOTE: hit_now = rk_match;
			default:                  hit_now = 1'b0;
		endcase
	end

	// Write-back decisions, taken in the decide cycle.
	assign is_add    = (act_q == mkvt_pkg::ACT_ADD);
	assign write_add = is_add && (len_q != 64'd0) && !dup_q && free_found_q;
	assign write_rem = ((act_q == mkvt_pkg::ACT_REM_BOTH) ||
	                    (act_q == mkvt_pkg::ACT_REM_REMOTE)) && hit_found_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wrec  = '0;
		if (state_q == S_CLEAR) begin
			// clear the live bit of every entry after reset
			ram_we = 1'b1;
		end else if (state_q == S_EVAL && write_add) begin
			ram_we          = 1'b1;
			ram_waddr       = free_idx_q;
			ram_wrec.live   = 1'b1;
			ram_wrec.lkey   = lkey_q;
			ram_wrec.rkey   = rkey_q;
			ram_wrec.base   = base_q;
			ram_wrec.length = len_q;
			ram_wrec.access = acc_q & ~strip_q;
		end else if (state_q == S_EVAL && write_rem) begin
			ram_we        = 1'b1;
			ram_waddr     = hit_idx_q;
			ram_wrec      = hit_rec_q;
			ram_wrec.live = 1'b0;
		end
	end

	// Configuration registers: taken at any time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enforce_q <= 1'b1;
			strip_q   <= 64'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mkvt_pkg::CFG_ENFORCE: enforce_q <= cfg_wdata[0];
				mkvt_pkg::CFG_STRIP:   strip_q   <= cfg_wdata;
				default:               enforce_q <= enforce_q;
			endcase
		end
	end

	// Request payload: hold while an item is in flight.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q  <= req.action;
			lkey_q <= req.local_key;
			rkey_q <= req.remote_key;
			base_q <= req.region_base;
			len_q  <= req.region_length;
			acc_q  <= req.access_bits;
		end
	end

	// Sequencer: clearing pass, scan, decide, range check, hand off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cnt_q        <= '0;
			rd_valid_s1  <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			hit_found_q  <= 1'b0;
			hit_idx_q    <= '0;
			hit_rec_q    <= '0;
			dup_q        <= 1'b0;
			rec_end_q    <= '0;
			req_end_q    <= '0;
			extra_bits_q <= 1'b0;
			status_q     <= mkvt_pkg::ST_OK;
			out_valid_q  <= 1'b0;
			out_status_q <= mkvt_pkg::ST_OK;
		end else begin
			rd_valid_s1 <= scan_issue;
			// the final state reloads the register itself when it frees up
			if (out_valid_q && rsp.ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					if (cnt_q == CW'(ENTRIES - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end

				S_IDLE: begin
					if (req.valid) begin
						cnt_q        <= '0;
						free_found_q <= 1'b0;
						hit_found_q  <= 1'b0;
						dup_q        <= 1'b0;
						if (!enforce_q) begin
							// no tracking: answer at once, leave the table alone
							status_q <= (req.action == mkvt_pkg::ACT_VALIDATE) ?
							            mkvt_pkg::ST_NO_ENTRY : mkvt_pkg::ST_OK;
							state_q  <= S_FINISH;
						end else begin
							status_q <= mkvt_pkg::ST_OK;
							state_q  <= S_SCAN;
						end
					end
				end

				S_SCAN: begin
					if (scan_issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (rd_valid_s1) begin
						// keep the lowest-index free slot and the lowest-index hit
						if (!rd_rec.live && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= cnt_q[AW-1:0] - AW'(1);
						end
						if (hit_now && !hit_found_q) begin
							hit_found_q <= 1'b1;
							hit_idx_q   <= cnt_q[AW-1:0] - AW'(1);
							hit_rec_q   <= rd_rec;
						end
						if (lk_match || rk_match) begin
							dup_q <= 1'b1;
						end
					end
					if (scan_done) begin
						state_q <= S_EVAL;
					end
				end

				S_EVAL: begin
					rec_end_q    <= {1'b0, hit_rec_q.base} + {1'b0, hit_rec_q.length};
					req_end_q    <= {1'b0, base_q} + {1'b0, len_q};
					extra_bits_q <= |(acc_q & ~hit_rec_q.access);
					unique case (act_q)
						mkvt_pkg::ACT_ADD: begin
							priority if (len_q == 64'd0) begin
								status_q <= mkvt_pkg::ST_INVALID;
							end else if (dup_q) begin
								status_q <= mkvt_pkg::ST_EXISTS;
							end else if (!free_found_q) begin
								status_q <= mkvt_pkg::ST_FULL;
							end else begin
								status_q <= mkvt_pkg::ST_OK;
							end
						end
						mkvt_pkg::ACT_VALIDATE: begin
							if (!hit_found_q || hit_rec_q.rkey != rkey_q) begin
								status_q <= mkvt_pkg::ST_NO_ENTRY;
							end
						end
						default: begin
							if (!hit_found_q) begin
								status_q <= mkvt_pkg::ST_NO_ENTRY;
							end
						end
					endcase
					state_q <= S_CHECK;
				end

				S_CHECK: begin
					// containment with wrap detection, then the access subset
					if (act_q == mkvt_pkg::ACT_VALIDATE && status_q == mkvt_pkg::ST_OK) begin
						if (rec_end_q[64] || req_end_q[64] || (base_q < hit_rec_q.base) ||
						    (req_end_q[63:0] > rec_end_q[63:0]) || extra_bits_q) begin
							status_q <= mkvt_pkg::ST_INVALID;
						end
					end
					state_q <= S_FINISH;
				end

				S_FINISH: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[tb/mkvt_status_checker.sv]
// Status checker for the memory-key validation table: mirrors the record table and compares.
`timescale 1ns / 1ps

module mkvt_status_checker #(
	parameter int ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mkvt_in_if               req,
	mkvt_out_if              rsp,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_wdata,
	output int               mismatches,
	output int               outstanding
);
	import mkvt_pkg::*;

	logic        enforce;
	logic [63:0] strip_mask;
	logic        live     [ENTRIES];
	logic [31:0] key_l    [ENTRIES];
	logic [31:0] key_r    [ENTRIES];
	logic [63:0] rec_base [ENTRIES];
	logic [63:0] rec_len  [ENTRIES];
	logic [63:0] rec_acc  [ENTRIES];
	logic [2:0]  status_due [$];
	int          err_count;

	// Lowest live record matching the selected keys, -1 when none.
	function automatic int find_live(input bit by_local, input bit by_remote,
	                                 input logic [31:0] lk, input logic [31:0] rk);
		for (int i = 0; i < ENTRIES; i++) begin
			if (live[i] && (!by_local || key_l[i] == lk) && (!by_remote || key_r[i] == rk))
				return i;
		end
		return -1;
	endfunction

	// Apply one request to the mirrored table and return the status it earns.
	function automatic logic [2:0] apply_request(input logic [1:0] act,
	                                             input logic [31:0] lk, input logic [31:0] rk,
	                                             input logic [63:0] base, input logic [63:0] len,
	                                             input logic [63:0] acc);
		int          slot;
		logic [64:0] rec_end;
		logic [64:0] req_end;
		if (!enforce)
			return (act == ACT_VALIDATE) ? ST_NO_ENTRY : ST_OK;
		case (act)
			ACT_ADD: begin
				if (len == '0)
					return ST_INVALID;
				if (find_live(1'b1, 1'b0, lk, rk) >= 0 || find_live(1'b0, 1'b1, lk, rk) >= 0)
					return ST_EXISTS;
				slot = -1;
				for (int i = ENTRIES - 1; i >= 0; i--) begin
					if (!live[i])
						slot = i;
				end
				if (slot < 0)
					return ST_FULL;
				key_l[slot]    = lk;
				key_r[slot]    = rk;
				rec_base[slot] = base;
				rec_len[slot]  = len;
				rec_acc[slot]  = acc & ~strip_mask;
				live[slot]     = 1'b1;
				return ST_OK;
			end
			ACT_VALIDATE: begin
				slot = find_live(1'b1, 1'b0, lk, rk);
				if (slot < 0 || key_r[slot] != rk)
					return ST_NO_ENTRY;
				rec_end = {1'b0, rec_base[slot]} + {1'b0, rec_len[slot]};
				req_end = {1'b0, base} + {1'b0, len};
				// a carry out of bit 63 means that end wraps past 2^64
				if (rec_end[64] || req_end[64] || base < rec_base[slot] ||
				    req_end[63:0] > rec_end[63:0] || (acc & ~rec_acc[slot]) != '0)
					return ST_INVALID;
				return ST_OK;
			end
			default: begin
				slot = find_live(act == ACT_REM_BOTH, 1'b1, lk, rk);
				if (slot < 0)
					return ST_NO_ENTRY;
				live[slot] = 1'b0;
				return ST_OK;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [2:0] want;
		if (!arst_n) begin
			enforce    = 1'b1;
			strip_mask = 64'd8;
			for (int i = 0; i < ENTRIES; i++)
				live[i] = 1'b0;
			status_due.delete();
			err_count   = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ENFORCE)
					enforce = cfg_wdata[0];
				else
					strip_mask = cfg_wdata;
			end
			if (rsp.valid && rsp.ready) begin
				if (status_due.size() == 0) begin
					$display("%0t: status %0d arrived, expected none", $time, rsp.status);
					err_count++;
				end else begin
					want = status_due.pop_front();
					if (rsp.status !== want) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
						         $time, want, rsp.status);
						err_count++;
					end
				end
			end
			if (req.valid && req.ready)
				status_due.push_back(apply_request(req.action, req.local_key, req.remote_key,
				                                   req.region_base, req.region_length,
				                                   req.access_bits));
			mismatches  <= err_count;
			outstanding <= status_due.size();
		end
	end

endmodule

[tb/memory_key_validation_table_tb.sv]
// Testbench top for the memory-key validation table: stimulus, idling and verdict.
`timescale 1ns / 1ps

module memory_key_validation_table_tb;
	import mkvt_pkg::*;

	localparam int ENTRIES   = 64;
	localparam int RING      = 32;   // recent adds kept for follow-up requests
	localparam int POOL      = 160;  // key pool, larger than the table so it can fill
	localparam int WDOG_MAX  = 4000; // cycles in which no item moves on either channel

	typedef struct {
		logic [1:0]  action;
		logic [31:0] lkey;
		logic [31:0] rkey;
		logic [63:0] base;
		logic [63:0] length;
		logic [63:0] access;
	} req_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_wdata;
	int          mismatches;
	int          outstanding;
	int          quiet_cycles;
	bit          steady;     // no idling on either side while set

	logic [31:0] key_pool   [POOL];
	req_item_t   recent_add [RING];
	int          recent_n;
	int          recent_wr;

	mkvt_in_if  req_ch ();
	mkvt_out_if rsp_ch ();

	memory_key_validation_table #(.ENTRIES(ENTRIES)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mkvt_status_checker #(.ENTRIES(ENTRIES)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Response side: stall about a third of the cycles, never while steady.
	always @(negedge clk) begin
		if (steady)
			rsp_ch.ready <= 1'b1;
		else
			rsp_ch.ready <= ($urandom_range(99) >= 33);
	end

	// Watchdog: count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WDOG_MAX) begin
				$display("%0t: no item moved for %0d cycles", $time, WDOG_MAX);
				$display("memory_key_validation_table_tb: FAIL");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly pool keys so duplicates and hits happen; now and then a fresh one.
	function automatic logic [31:0] pick_key();
		return ($urandom_range(99) < 88) ? key_pool[$urandom_range(POOL - 1)] : $urandom;
	endfunction

	// Build one random request. Validates and removes mostly follow up on recent adds
	// so they reach live records; the rest is noise.
	function automatic req_item_t make_item(input int add_pct, input int val_pct);
		req_item_t it;
		req_item_t src;
		int        roll;
		int        pick;
		logic [63:0] off;
		logic [63:0] room;
		roll        = $urandom_range(99);
		it.action   = ACT_ADD;
		it.lkey     = pick_key();
		it.rkey     = pick_key();
		it.base     = rand64();
		it.length   = rand64();
		it.access   = rand64();
		if ($urandom_range(99) < 5) begin
			// raw noise on every field, any action
			it.action = 2'($urandom_range(3));
			return it;
		end
		if (roll < add_pct) begin
			if ($urandom_range(3) != 0)
				it.base = {32'h0, $urandom};
			else if ($urandom_range(7) == 0)
				it.base = '1;
			pick = $urandom_range(99);
			if (pick < 6)
				it.length = '0;
			else if (pick < 10)
				it.length = '1;
			else if (pick < 16)
				it.length = rand64();
			else
				it.length = 64'($urandom_range(1, 1 << 20));
			if ($urandom_range(1) == 0)
				it.access = 64'($urandom_range(15));
			return it;
		end
		if (recent_n == 0 || $urandom_range(99) >= 85) begin
			it.action = (roll < add_pct + val_pct) ? ACT_VALIDATE :
			            ($urandom_range(1) ? ACT_REM_BOTH : ACT_REM_REMOTE);
			return it;
		end
		src     = recent_add[$urandom_range(recent_n - 1)];
		it.lkey = src.lkey;
		it.rkey = ($urandom_range(9) == 0) ? pick_key() : src.rkey;
		if (roll < add_pct + val_pct) begin
			it.action = ACT_VALIDATE;
			// carve a subrange out of the record's range
			off       = (src.length == '1) ? (rand64() & 64'hFFFF) :
			            rand64() % (src.length + 64'd1);
			room      = src.length - off;
			it.base   = src.base + off;
			it.length = (room == '1) ? rand64() : rand64() % (room + 64'd1);
			it.access = ($urandom_range(4) == 0) ? src.access : (src.access & rand64());
			if ($urandom_range(3) == 0) begin
				// push one check over its edge
				case ($urandom_range(3))
					0: it.base = it.base - 64'd1;
					1: it.length = it.length + 64'(1 + $urandom_range(7));
					2: it.access = it.access | (64'h1 << $urandom_range(63));
					default: it.base = rand64();
				endcase
			end
		end else begin
			it.action = $urandom_range(1) ? ACT_REM_BOTH : ACT_REM_REMOTE;
			if ($urandom_range(9) == 0)
				it.lkey = pick_key();
		end
		return it;
	endfunction

	// Present one item and hold it until accepted; return at the falling edge after.
	task automatic drive_request(input req_item_t it);
		if (!steady && $urandom_range(99) < 33) begin
			req_ch.valid = 1'b0;
			repeat (($urandom_range(99) < 5) ? $urandom_range(10, 90) : $urandom_range(1, 6))
				@(negedge clk);
		end
		req_ch.valid         = 1'b1;
		req_ch.action        = it.action;
		req_ch.local_key     = it.lkey;
		req_ch.remote_key    = it.rkey;
		req_ch.region_base   = it.base;
		req_ch.region_length = it.length;
		req_ch.access_bits   = it.access;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
		if (it.action == ACT_ADD) begin
			recent_add[recent_wr] = it;
			recent_wr = (recent_wr + 1) % RING;
			if (recent_n < RING)
				recent_n++;
		end
	endtask

	task automatic send(input logic [1:0] act, input logic [31:0] lk, input logic [31:0] rk,
	                    input logic [63:0] base, input logic [63:0] len,
	                    input logic [63:0] acc);
		req_item_t it;
		it.action = act;
		it.lkey   = lk;
		it.rkey   = rk;
		it.base   = base;
		it.length = len;
		it.access = acc;
		drive_request(it);
	endtask

	task automatic random_phase(input int count, input int add_pct, input int val_pct);
		for (int n = 0; n < count; n++)
			drive_request(make_item(add_pct, val_pct));
	endtask

	// Drop valid and wait until every status has come back and the block has settled.
	task automatic drain();
		req_ch.valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	initial begin
		arst_n               = 1'b0;
		steady               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_ENFORCE;
		cfg_wdata            = '0;
		req_ch.valid         = 1'b0;
		req_ch.action        = ACT_ADD;
		req_ch.local_key     = '0;
		req_ch.remote_key    = '0;
		req_ch.region_base   = '0;
		req_ch.region_length = '0;
		req_ch.access_bits   = '0;
		rsp_ch.ready         = 1'b0;
		recent_n             = 0;
		recent_wr            = 0;
		for (int i = 0; i < POOL; i++)
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		write_reg(CFG_STRIP, 64'd8);

		// Directed: zero length, duplicates on either key, stripped atomic bit,
		// wrapping record and query ranges, range edges, both removes and slot reuse.
		send(ACT_ADD,        32'h0,         32'h0,         64'h0,    64'h0,    '1);
		send(ACT_ADD,        32'h0,         32'h0,         64'h0,    '1,       '1);
		send(ACT_ADD,        32'h0,         32'h5,         64'h0,    64'h1,    64'h0);
		send(ACT_ADD,        32'h7,         32'h0,         64'h0,    64'h1,    64'h0);
		send(ACT_VALIDATE,   32'h0,         32'h0,         64'h0,    '1,       ~64'h8);
		send(ACT_VALIDATE,   32'h0,         32'h0,         64'h0,    '1,       '1);
		send(ACT_VALIDATE,   32'h0,         32'h1,         64'h0,    64'h1,    64'h0);
		send(ACT_VALIDATE,   32'h9,         32'h0,         64'h0,    64'h1,    64'h0);
		send(ACT_ADD,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10, 64'h0);
		send(ACT_VALIDATE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, 64'h0,  64'h0);
		send(ACT_ADD,        32'd100,       32'd200,       64'h1000, 64'h1000, 64'h3);
		send(ACT_VALIDATE,   32'd100,       32'd200,       64'h1000, 64'h1000, 64'h3);
		send(ACT_VALIDATE,   32'd100,       32'd200,       64'hFFF,  64'h1,    64'h0);
		send(ACT_VALIDATE,   32'd100,       32'd200,       64'h1800, 64'h801,  64'h0);
		send(ACT_VALIDATE,   32'd100,       32'd200,       '1,       64'h2,    64'h0);
		send(ACT_VALIDATE,   32'd100,       32'd200,       64'h2000, 64'h0,    64'h0);
		send(ACT_REM_BOTH,   32'd100,       32'd201,       64'h0,    64'h0,    64'h0);
		send(ACT_REM_REMOTE, 32'd0,         32'd200,       64'h0,    64'h0,    64'h0);
		send(ACT_REM_REMOTE, 32'd0,         32'd200,       64'h0,    64'h0,    64'h0);
		send(ACT_REM_BOTH,   32'h0,         32'h0,         64'h0,    64'h0,    64'h0);
		send(ACT_ADD,        32'd100,       32'd200,       64'h1000, 64'h10,   64'h4);
		drain();

		// Enforcement off: adds and removes pass, validate finds nothing.
		write_reg(CFG_ENFORCE, 64'd0);
		send(ACT_ADD,        32'h0,   32'h0,   64'h0,    64'h0,  64'h0);
		send(ACT_VALIDATE,   32'd100, 32'd200, 64'h1000, 64'h10, 64'h4);
		send(ACT_REM_REMOTE, 32'd0,   32'd200, 64'h0,    64'h0,  64'h0);
		send(ACT_REM_BOTH,   32'h5,   32'h5,   64'h0,    64'h0,  64'h0);
		drain();

		// Back on: the record kept across the off period must still validate.
		write_reg(CFG_ENFORCE, 64'd1);
		send(ACT_VALIDATE,   32'd100, 32'd200, 64'h1000, 64'h10, 64'h4);

		// Random phases across mask settings, with a fill phase to hit table full.
		random_phase(400, 40, 35);
		drain();
		write_reg(CFG_STRIP, rand64());
		random_phase(200, 85, 10);
		drain();
		write_reg(CFG_ENFORCE, 64'd0);
		random_phase(100, 35, 35);
		drain();
		write_reg(CFG_ENFORCE, 64'd1);
		write_reg(CFG_STRIP, 64'd0);
		steady = 1'b1;
		random_phase(200, 20, 40);
		steady = 1'b0;
		random_phase(150, 40, 35);
		drain();
		write_reg(CFG_STRIP, '1);
		random_phase(150, 40, 35);
		drain();
		write_reg(CFG_STRIP, 64'd8);
		random_phase(150, 40, 35);

		// Let the last statuses come back, then allow a full item's time more.
		drain();
		repeat (ENTRIES + 8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("memory_key_validation_table_tb: PASS");
		else
			$display("memory_key_validation_table_tb: FAIL");
		$finish;
	end

endmodule

[filelist.f]
hdl/mkvt_pkg.sv
hdl/mkvt_in_if.sv
hdl/mkvt_out_if.sv
hdl/mkvt_ram.sv
hdl/memory_key_validation_table.sv
tb/mkvt_status_checker.sv
tb/memory_key_validation_table_tb.sv
